/* rtl/bdpc_pkg.sv */
// Shared types and constants for the button debounce press classifier.
package bdpc_pkg;

   // Width of each configuration register
   localparam int unsigned CFG_WIDTH = 16;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TICKS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHORT_LIMIT    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_LIMIT     = 2'd2;

   // Reset values of the configuration registers
   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_TICKS_RESET = 16'd50;
   localparam logic [CFG_WIDTH-1:0] SHORT_LIMIT_RESET    = 16'd350;
   localparam logic [CFG_WIDTH-1:0] LONG_LIMIT_RESET     = 16'd1000;

   // Press class codes
   typedef enum logic [1:0] {
      CLASS_NONE    = 2'd0,
      CLASS_SHORT   = 2'd1,
      CLASS_REGULAR = 2'd2,
      CLASS_LONG    = 2'd3
   } press_class_type;

   // Configuration handed from the register block to the press machine
   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_ticks;
      logic [CFG_WIDTH-1:0] short_limit;
      logic [CFG_WIDTH-1:0] long_limit;
   } cfg_type;

endpackage

/* rtl/bdpc_csr.sv */
// Configuration registers of the button debounce press classifier.
module bdpc_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    write_en,
   input  logic [bdpc_pkg::CSR_INDEX_WIDTH-1:0]    write_index,
   input  logic [bdpc_pkg::CFG_WIDTH-1:0]          write_data,
   output bdpc_pkg::cfg_type                       cfg
);

   bdpc_pkg::cfg_type cfg_ff;

   // Register writes; an unused index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= bdpc_pkg::DEBOUNCE_TICKS_RESET;
         cfg_ff.short_limit    <= bdpc_pkg::SHORT_LIMIT_RESET;
         cfg_ff.long_limit     <= bdpc_pkg::LONG_LIMIT_RESET;
      end else if (write_en) begin
         case (write_index)
            bdpc_pkg::CSR_DEBOUNCE_TICKS: cfg_ff.debounce_ticks <= write_data;
            bdpc_pkg::CSR_SHORT_LIMIT:    cfg_ff.short_limit    <= write_data;
            bdpc_pkg::CSR_LONG_LIMIT:     cfg_ff.long_limit     <= write_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/bdpc_fsm.sv */
// Debounce and press-duration state machine with its registered result.
module bdpc_fsm #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       pin_level,
   input  bdpc_pkg::cfg_type          cfg,
   output bdpc_pkg::press_class_type  press_class,
   output logic                       press_done
);

   // Compare width covers both the counters and the 16-bit registers
   localparam int unsigned CMP_WIDTH =
      (COUNT_WIDTH > bdpc_pkg::CFG_WIDTH) ? COUNT_WIDTH : bdpc_pkg::CFG_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_PRESSING  = 2'd1,
      PH_VERIFIED  = 2'd2,
      PH_RELEASING = 2'd3
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]    hold_count_ff, hold_count_in;
   logic [COUNT_WIDTH-1:0]    up_count_ff, up_count_in;
   bdpc_pkg::press_class_type last_class_ff, last_class_in;
   logic                      done_ff, done_in;

   logic                      down;
   logic [COUNT_WIDTH-1:0]    hold_inc, up_inc;
   logic [CMP_WIDTH-1:0]      hold_wide, up_wide;
   logic [CMP_WIDTH-1:0]      debounce_wide, short_wide, long_wide;

   assign down = ~pin_level;

   // Saturating increments
   assign hold_inc = (hold_count_ff == COUNT_MAX) ? COUNT_MAX
                                                  : hold_count_ff + 1'b1;
   assign up_inc   = (up_count_ff == COUNT_MAX) ? COUNT_MAX
                                                : up_count_ff + 1'b1;

   // Zero-extend everything to a common width for the compares
   assign hold_wide     = CMP_WIDTH'(hold_inc);
   assign up_wide       = CMP_WIDTH'(up_inc);
   assign debounce_wide = CMP_WIDTH'(cfg.debounce_ticks);
   assign short_wide    = CMP_WIDTH'(cfg.short_limit);
   assign long_wide     = CMP_WIDTH'(cfg.long_limit);

   // Next state for one tick
   always_comb begin
      phase_in      = phase_ff;
      hold_count_in = hold_count_ff;
      up_count_in   = up_count_ff;
      last_class_in = last_class_ff;
      done_in       = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (down) begin
               hold_count_in = '0;
               phase_in      = PH_PRESSING;
            end
         end
         PH_PRESSING: begin
            if (down) begin
               if (hold_wide >= debounce_wide) begin
                  hold_count_in = '0;
                  phase_in      = PH_VERIFIED;
               end else begin
                  hold_count_in = hold_inc;
               end
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_VERIFIED: begin
            if (down) begin
               hold_count_in = hold_inc;
            end else begin
               up_count_in = '0;
               phase_in    = PH_RELEASING;
            end
         end
         PH_RELEASING: begin
            if (down) begin
               // bounce back to down: keep the held count
               phase_in = PH_VERIFIED;
            end else begin
               up_count_in = up_inc;
               if (up_wide >= debounce_wide) begin
                  hold_count_in = hold_inc;
                  if (hold_wide < short_wide) begin
                     last_class_in = bdpc_pkg::CLASS_SHORT;
                  end else if (hold_wide < long_wide) begin
                     last_class_in = bdpc_pkg::CLASS_REGULAR;
                  end else begin
                     last_class_in = bdpc_pkg::CLASS_LONG;
                  end
                  done_in  = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // State and result registers advance only on an input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         hold_count_ff <= '0;
         up_count_ff   <= '0;
         last_class_ff <= bdpc_pkg::CLASS_NONE;
         done_ff       <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         hold_count_ff <= hold_count_in;
         up_count_ff   <= up_count_in;
         last_class_ff <= last_class_in;
         done_ff       <= done_in;
      end
   end

   assign press_class = last_class_ff;
   assign press_done  = done_ff;

endmodule

/* rtl/button_debounce_press_classifier.sv */
// Top level of the button debounce press classifier.
// One request per polling tick carries the raw level of an active-low button;
// each request produces exactly one response holding the sticky class of the
// last press (none, short, regular, long) and a done flag that is set on the
// tick a press is classified. A press and a release must each hold for
// more than debounce_ticks ticks; held ticks are counted with saturation at
// 2^COUNT_WIDTH-1 and compared against short_limit and long_limit. The block
// takes one tick per clock cycle: the state machine updates on the request
// transfer and the result sits in the response register, and a new request is
// accepted whenever that register is empty or being drained in the same cycle.
// Configuration writes are always accepted and should be made while no request is
// in flight.
module button_debounce_press_classifier #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // tick request
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_pin_level,
   // classification response
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_press_class,
   output logic                                 rsp_press_done,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bdpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bdpc_pkg::CFG_WIDTH-1:0]       csr_data
);

   bdpc_pkg::cfg_type         cfg;
   bdpc_pkg::press_class_type press_class;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      step;

   assign csr_ready = 1'b1;
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign step      = req_valid & req_ready;

   bdpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .write_en    (csr_valid),
      .write_index (csr_index),
      .write_data  (csr_data),
      .cfg         (cfg)
   );

   bdpc_fsm #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_fsm (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .pin_level   (req_pin_level),
      .cfg         (cfg),
      .press_class (press_class),
      .press_done  (rsp_press_done)
   );

   // Response register occupancy
   assign rsp_valid_in = step | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_press_class = press_class;

endmodule

/* test/button_debounce_press_classifier_tb.sv */
// Self-checking testbench for the button debounce press classifier.
`timescale 1ns / 1ps

module button_debounce_press_classifier_tb;

   localparam int unsigned CLOCK_PERIOD    = 8;
   localparam int unsigned RESET_CYCLES    = 11;
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned CYCLE_LIMIT     = 1_500_000;
   localparam int unsigned COUNT_WIDTH     = 16;
   localparam int unsigned CFG_WIDTH       = bdpc_pkg::CFG_WIDTH;
   localparam int unsigned CSR_INDEX_WIDTH = bdpc_pkg::CSR_INDEX_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [CFG_WIDTH-1:0]   CFG_MAX   = {CFG_WIDTH{1'b1}};

   // index past the last register; writes to it must be ignored
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_PRESSING  = 2'd1,
      PH_VERIFIED  = 2'd2,
      PH_RELEASING = 2'd3
   } button_phase_type;

   typedef struct packed {
      bdpc_pkg::press_class_type cls;
      logic                      done;
   } press_result_type;

   // Tracks the press machine and the responses it should produce
   class press_scoreboard;
      logic [CFG_WIDTH-1:0]      debounce_ticks;
      logic [CFG_WIDTH-1:0]      short_limit;
      logic [CFG_WIDTH-1:0]      long_limit;
      button_phase_type          phase;
      logic [COUNT_WIDTH-1:0]    hold_count;
      logic [COUNT_WIDTH-1:0]    up_count;
      bdpc_pkg::press_class_type last_class;
      press_result_type          expected_q[$];
      int unsigned               mismatches;
      int unsigned               ticks;
      int unsigned               responses;
      int unsigned               presses;
      int unsigned               settings;

      function new();
         debounce_ticks = bdpc_pkg::DEBOUNCE_TICKS_RESET;
         short_limit    = bdpc_pkg::SHORT_LIMIT_RESET;
         long_limit     = bdpc_pkg::LONG_LIMIT_RESET;
         phase          = PH_IDLE;
         hold_count     = '0;
         up_count       = '0;
         last_class     = bdpc_pkg::CLASS_NONE;
         mismatches     = 0;
         ticks          = 0;
         responses      = 0;
         presses        = 0;
         settings       = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] index, logic [CFG_WIDTH-1:0] data);
         case (index)
            bdpc_pkg::CSR_DEBOUNCE_TICKS: debounce_ticks = data;
            bdpc_pkg::CSR_SHORT_LIMIT:    short_limit    = data;
            bdpc_pkg::CSR_LONG_LIMIT:     long_limit     = data;
            default: ;
         endcase
      endfunction

      // saturating counter step
      function logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] v);
         return (v == COUNT_MAX) ? v : v + 1'b1;
      endfunction

      // advance the machine by one accepted tick and queue its response
      function void note_tick(logic pin);
         logic             down;
         logic             done;
         press_result_type r;
         down = (pin == 1'b0);
         done = 1'b0;
         case (phase)
            PH_IDLE: begin
               if (down) begin
                  hold_count = '0;
                  phase      = PH_PRESSING;
               end
            end
            PH_PRESSING: begin
               if (down) begin
                  hold_count = bump(hold_count);
                  if (hold_count >= debounce_ticks) begin
                     hold_count = '0;
                     phase      = PH_VERIFIED;
                  end
               end else begin
                  phase = PH_IDLE;
               end
            end
            PH_VERIFIED: begin
               if (down) begin
                  hold_count = bump(hold_count);
               end else begin
                  up_count = '0;
                  phase    = PH_RELEASING;
               end
            end
            default: begin
               // a bounce back to down resumes the press with its count kept
               if (!down) begin
                  up_count = bump(up_count);
                  if (up_count >= debounce_ticks) begin
                     hold_count = bump(hold_count);
                     if (hold_count < short_limit) begin
                        last_class = bdpc_pkg::CLASS_SHORT;
                     end else if (hold_count < long_limit) begin
                        last_class = bdpc_pkg::CLASS_REGULAR;
                     end else begin
                        last_class = bdpc_pkg::CLASS_LONG;
                     end
                     done  = 1'b1;
                     phase = PH_IDLE;
                  end
               end else begin
                  phase = PH_VERIFIED;
               end
            end
         endcase
         r.cls  = last_class;
         r.done = done;
         expected_q.push_back(r);
         ticks++;
      endfunction

      // compare one response transfer with the oldest expectation
      function void check_result(logic [1:0] cls, logic done);
         press_result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: class %0d done %0b", cls, done);
            return;
         end
         want = expected_q.pop_front();
         responses++;
         if (want.done)
            presses++;
         if (cls !== want.cls || done !== want.done) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch on response %0d: class %0d expected %0d, done %0b expected %0b",
                        responses, cls, want.cls, done, want.done);
         end
      endfunction
   endclass

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_pin_level = 1'b1;
   logic                       rsp_ready     = 1'b0;
   logic                       csr_valid     = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index     = '0;
   logic [CFG_WIDTH-1:0]       csr_data      = '0;
   logic                       req_ready;
   logic                       rsp_valid;
   logic [1:0]                 rsp_press_class;
   logic                       rsp_press_done;
   logic                       csr_ready;

   press_scoreboard sb;
   int unsigned     send_idle_pct  = 0;
   int unsigned     recv_stall_pct = 0;
   int unsigned     cycle_count    = 0;

   button_debounce_press_classifier #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pin_level   (req_pin_level),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_press_class (rsp_press_class),
      .rsp_press_done  (rsp_press_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // response side: check each transfer, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_press_class, rsp_press_done);
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // one tick request, with random idle cycles ahead of it
   task automatic send_tick(input logic pin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pin_level <= pin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_tick(pin);
   endtask

   task automatic send_run(input logic pin, input int unsigned n);
      for (int unsigned i = 0; i < n; i++)
         send_tick(pin);
   endtask

   // wait until every queued response has been drained
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CFG_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(index, data);
   endtask

   // reprogram all registers once the block has gone quiet
   task automatic apply_settings(input logic [CFG_WIDTH-1:0] deb,
                                 input logic [CFG_WIDTH-1:0] short_lim,
                                 input logic [CFG_WIDTH-1:0] long_lim);
      drain_results();
      csr_write(bdpc_pkg::CSR_DEBOUNCE_TICKS, deb);
      csr_write(bdpc_pkg::CSR_SHORT_LIMIT, short_lim);
      csr_write(bdpc_pkg::CSR_LONG_LIMIT, long_lim);
      csr_write(CSR_UNUSED, CFG_WIDTH'($urandom_range(CFG_MAX)));
      csr_valid <= 1'b0;
      sb.settings++;
   endtask

   function automatic logic [CFG_WIDTH-1:0] pick_limit();
      case ($urandom_range(9))
         0:       return '0;
         1:       return CFG_MAX;
         default: return CFG_WIDTH'($urandom_range(1, 14));
      endcase
   endfunction

   // mostly well-formed press, with optional bounces on both edges
   task automatic send_press();
      int unsigned deb;
      int unsigned bounce_max;
      deb        = {16'd0, sb.debounce_ticks};
      bounce_max = (deb == 0) ? 1 : deb;
      if ($urandom_range(3) == 0) begin
         send_run(1'b0, $urandom_range(1, bounce_max));
         send_run(1'b1, $urandom_range(1, 2));
      end
      send_run(1'b0, 1 + deb + $urandom_range(0, 16));
      if ($urandom_range(3) == 0) begin
         send_run(1'b1, $urandom_range(1, bounce_max));
         send_run(1'b0, $urandom_range(1, 3));
      end
      send_run(1'b1, 1 + deb + $urandom_range(0, 3));
   endtask

   initial begin
      int unsigned target;
      int unsigned noise_len;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: a press that bounces straight back to idle
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);

      // short press with a release bounce, then regular and long presses
      apply_settings(16'd2, 16'd3, 16'd5);
      send_run(1'b0, 3);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_run(1'b1, 3);
      send_run(1'b0, 5);
      send_run(1'b1, 3);
      send_run(1'b0, 7);
      send_run(1'b1, 3);

      // zero debounce with crossed limits
      apply_settings(16'd0, CFG_MAX, 16'd0);
      send_run(1'b0, 2);
      send_run(1'b1, 2);

      // random presses and noise under three idle patterns
      for (int unsigned mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct  = 32;
               recv_stall_pct = 45;
            end
            1: begin
               send_idle_pct  = 45;
               recv_stall_pct = 32;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int unsigned sub = 0; sub < 4; sub++) begin
            apply_settings(CFG_WIDTH'($urandom_range(0, 4)), pick_limit(), pick_limit());
            target = sb.ticks + 75;
            while (sb.ticks < target) begin
               if ($urandom_range(4) == 0) begin
                  noise_len = $urandom_range(1, 8);
                  for (int unsigned i = 0; i < noise_len; i++)
                     send_tick(1'($urandom_range(1)));
               end else begin
                  send_press();
               end
            end
         end
      end

      // reset values again: one debounced short press
      apply_settings(bdpc_pkg::DEBOUNCE_TICKS_RESET, bdpc_pkg::SHORT_LIMIT_RESET,
                     bdpc_pkg::LONG_LIMIT_RESET);
      send_run(1'b0, 51 + 100);
      send_run(1'b1, 51);

      drain_results();
      $display("summary: %0d ticks, %0d responses, %0d presses classified, %0d settings",
               sb.ticks, sb.responses, sb.presses, sb.settings);
      $display("summary: bounces, noise, zero debounce, crossed and extreme limits; %0d mismatches",
               sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
